@@ rtl/cvcs_pkg.sv @@
// shared types, constants and codes for the chunked voxel cell store
package cvcs_pkg;

    // fixed field widths
    localparam int DATA_W     = 32;
    localparam int COORD_W    = 8;
    localparam int COUNT_W    = 3;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // parameter defaults
    localparam int CELLS_PER_CHUNK_EDGE_DEF = 8;
    localparam int MAX_CHUNKS_PER_AXIS_DEF  = 4;

    // reset value of each chunk count
    localparam logic [COUNT_W-1:0] CHUNKS_RESET = 3'd4;

    // register indexes on the configuration port
    localparam logic [1:0] REG_CHUNKS_X = 2'd0;
    localparam logic [1:0] REG_CHUNKS_Y = 2'd1;
    localparam logic [1:0] REG_CHUNKS_Z = 2'd2;

    // result status codes
    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // request operations
    typedef enum logic [1:0] {
        OP_GET = 2'd0,
        OP_SET = 2'd1,
        OP_INC = 2'd2,
        OP_DEC = 2'd3
    } op_t;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_EXEC
    } state_t;

    // chunk counts from the register file
    typedef struct packed {
        logic [COUNT_W-1:0] chunks_x;
        logic [COUNT_W-1:0] chunks_y;
        logic [COUNT_W-1:0] chunks_z;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic ready;
        logic calc_en;
        logic read_en;
        logic exec_en;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic req_valid;
        logic clear_last;
        logic out_free;
    } stat_t;

endpackage

@@ rtl/cvcs_req_if.sv @@
// request channel: operation, coordinates and write value
interface cvcs_req_if;
    logic                                valid;
    logic                                ready;
    cvcs_pkg::op_t                       op;
    logic [cvcs_pkg::COORD_W-1:0]        x_coord;
    logic [cvcs_pkg::COORD_W-1:0]        y_coord;
    logic [cvcs_pkg::COORD_W-1:0]        z_coord;
    logic signed [cvcs_pkg::DATA_W-1:0]  write_value;

    modport source (
        output valid, op, x_coord, y_coord, z_coord, write_value,
        input  ready
    );

    modport sink (
        input  valid, op, x_coord, y_coord, z_coord, write_value,
        output ready
    );
endinterface

@@ rtl/cvcs_rsp_if.sv @@
// response channel: read value and status
interface cvcs_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [cvcs_pkg::DATA_W-1:0]  read_value;
    logic                                status;

    modport source (
        output valid, read_value, status,
        input  ready
    );

    modport sink (
        input  valid, read_value, status,
        output ready
    );
endinterface

@@ rtl/chunked_voxel_cell_store.sv @@
// top level of the chunked voxel cell store
//
// usage
//   req: valid/ready channel carrying op, x/y/z cell coordinates and a write value.
//   rsp: valid/ready channel returning one word per request: read value and status.
//   apb-style port: chunks_along_x/y/z at byte addresses 0, 4, 8; write only while idle.
// timing
//   after reset a clearing pass zeroes the cell memory, one cell a cycle:
//   (MAX_CHUNKS_PER_AXIS * CELLS_PER_CHUNK_EDGE) cubed cells, 32768 by default.
//   req.ready stays low during that pass.
//   each request passes through four steps: accept, address/range, memory read, modify and write.
//   the result word is loaded into the output register in the modify and write step.
//   the memory reads the cell in the read step and writes it in the modify and write step.
// stalls
//   the result sits in an output register; the next request is accepted while it
//   waits, and the block holds in its execute step until the register is free.
module chunked_voxel_cell_store #(
    parameter int CELLS_PER_CHUNK_EDGE = cvcs_pkg::CELLS_PER_CHUNK_EDGE_DEF,
    parameter int MAX_CHUNKS_PER_AXIS  = cvcs_pkg::MAX_CHUNKS_PER_AXIS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    cvcs_req_if.sink                           req,
    cvcs_rsp_if.source                         rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cvcs_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [cvcs_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [cvcs_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);

    cvcs_pkg::cfg_t  cfg;
    cvcs_pkg::cmd_t  cmd;
    cvcs_pkg::stat_t stat;

    // configuration registers
    cvcs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // controller
    cvcs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // datapath
    cvcs_dp #(
        .CELLS_PER_CHUNK_EDGE (CELLS_PER_CHUNK_EDGE),
        .MAX_CHUNKS_PER_AXIS  (MAX_CHUNKS_PER_AXIS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cmd   (cmd),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

@@ rtl/cvcs_cfg.sv @@
// chunk count registers behind the apb-style configuration port
module cvcs_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cvcs_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [cvcs_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [cvcs_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    output cvcs_pkg::cfg_t                     cfg
);

    logic [cvcs_pkg::COUNT_W-1:0] chunks_x_reg, chunks_x_next;
    logic [cvcs_pkg::COUNT_W-1:0] chunks_y_reg, chunks_y_next;
    logic [cvcs_pkg::COUNT_W-1:0] chunks_z_reg, chunks_z_next;
    logic                         wr_en;
    logic [1:0]                   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // register write decode
    always_comb
    begin
        chunks_x_next = chunks_x_reg;
        chunks_y_next = chunks_y_reg;
        chunks_z_next = chunks_z_reg;
        if (wr_en)
        begin
            case (reg_idx)
                cvcs_pkg::REG_CHUNKS_X: chunks_x_next = pwdata[cvcs_pkg::COUNT_W-1:0];
                cvcs_pkg::REG_CHUNKS_Y: chunks_y_next = pwdata[cvcs_pkg::COUNT_W-1:0];
                cvcs_pkg::REG_CHUNKS_Z: chunks_z_next = pwdata[cvcs_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunks_x_reg <= cvcs_pkg::CHUNKS_RESET;
            chunks_y_reg <= cvcs_pkg::CHUNKS_RESET;
            chunks_z_reg <= cvcs_pkg::CHUNKS_RESET;
        end
        else
        begin
            chunks_x_reg <= chunks_x_next;
            chunks_y_reg <= chunks_y_next;
            chunks_z_reg <= chunks_z_next;
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            cvcs_pkg::REG_CHUNKS_X: prdata = cvcs_pkg::CFG_DATA_W'(chunks_x_reg);
            cvcs_pkg::REG_CHUNKS_Y: prdata = cvcs_pkg::CFG_DATA_W'(chunks_y_reg);
            cvcs_pkg::REG_CHUNKS_Z: prdata = cvcs_pkg::CFG_DATA_W'(chunks_z_reg);
            default:                prdata = '0;
        endcase
    end

    assign cfg.chunks_x = chunks_x_reg;
    assign cfg.chunks_y = chunks_y_reg;
    assign cfg.chunks_z = chunks_z_reg;

endmodule

@@ rtl/cvcs_ctrl.sv @@
// sequencing state machine: clearing pass, then calc, read and execute per word
module cvcs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  cvcs_pkg::stat_t stat,
    output cvcs_pkg::cmd_t  cmd
);

    cvcs_pkg::state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cvcs_pkg::ST_CLEAR: if (stat.clear_last) state_next = cvcs_pkg::ST_IDLE;
            cvcs_pkg::ST_IDLE:  if (stat.req_valid)  state_next = cvcs_pkg::ST_CALC;
            cvcs_pkg::ST_CALC:  state_next = cvcs_pkg::ST_READ;
            cvcs_pkg::ST_READ:  state_next = cvcs_pkg::ST_EXEC;
            cvcs_pkg::ST_EXEC:  if (stat.out_free)   state_next = cvcs_pkg::ST_IDLE;
            default:            state_next = cvcs_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cvcs_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            cvcs_pkg::ST_CLEAR: cmd.clear_en = 1'b1;
            cvcs_pkg::ST_IDLE:  cmd.ready    = 1'b1;
            cvcs_pkg::ST_CALC:  cmd.calc_en  = 1'b1;
            cvcs_pkg::ST_READ:  cmd.read_en  = 1'b1;
            cvcs_pkg::ST_EXEC:  cmd.exec_en  = stat.out_free;
            default:            cmd = '0;
        endcase
    end

endmodule

@@ rtl/cvcs_dp.sv @@
// datapath: request capture, range check, address, cell memory, output register
module cvcs_dp #(
    parameter int CELLS_PER_CHUNK_EDGE = cvcs_pkg::CELLS_PER_CHUNK_EDGE_DEF,
    parameter int MAX_CHUNKS_PER_AXIS  = cvcs_pkg::MAX_CHUNKS_PER_AXIS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cvcs_pkg::cfg_t  cfg,
    input  cvcs_pkg::cmd_t  cmd,
    output cvcs_pkg::stat_t stat,
    cvcs_req_if.sink        req,
    cvcs_rsp_if.source      rsp
);

    localparam int GRID_EDGE  = MAX_CHUNKS_PER_AXIS * CELLS_PER_CHUNK_EDGE;
    localparam int GRID_CELLS = GRID_EDGE * GRID_EDGE * GRID_EDGE;
    localparam int EDGE_W     = $clog2(GRID_EDGE);
    localparam int ADDR_W     = $clog2(GRID_CELLS);
    localparam int LIM_W      = cvcs_pkg::COORD_W + 1;
    localparam int DATA_W     = cvcs_pkg::DATA_W;

    // chunk count clamped to the grid
    function automatic logic [LIM_W-1:0] eff_count(input logic [cvcs_pkg::COUNT_W-1:0] c);
        logic [LIM_W-1:0] cw;
        cw = LIM_W'(c);
        if (cw > LIM_W'(MAX_CHUNKS_PER_AXIS))
            eff_count = LIM_W'(MAX_CHUNKS_PER_AXIS);
        else
            eff_count = cw;
    endfunction

    logic [DATA_W-1:0]            mem [GRID_CELLS];

    cvcs_pkg::op_t                op_reg;
    logic [cvcs_pkg::COORD_W-1:0] x_reg, y_reg, z_reg;
    logic [DATA_W-1:0]            wv_reg;
    logic [ADDR_W-1:0]            addr_reg, addr_next;
    logic                         in_range_reg, in_range_next;
    logic [DATA_W-1:0]            rdata_reg;
    logic [ADDR_W-1:0]            clr_cnt_reg, clr_cnt_next;
    logic                         out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]            out_value_reg, out_value_next;
    logic                         out_status_reg, out_status_next;

    logic                         accept;
    logic [LIM_W-1:0]             lim_x, lim_y, lim_z;
    logic [EDGE_W-1:0]            pos_x, pos_y, pos_z;
    logic [DATA_W-1:0]            new_value;
    logic                         mem_we;
    logic [ADDR_W-1:0]            mem_waddr;
    logic [DATA_W-1:0]            mem_wdata;

    assign accept    = cmd.ready && req.valid;
    assign req.ready = cmd.ready;

    // status to the controller
    assign stat.req_valid  = req.valid;
    assign stat.clear_last = (clr_cnt_reg == ADDR_W'(GRID_CELLS - 1));
    assign stat.out_free   = !out_valid_reg || rsp.ready;

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= req.op;
            x_reg  <= req.x_coord;
            y_reg  <= req.y_coord;
            z_reg  <= req.z_coord;
            wv_reg <= req.write_value;
        end
    end

    // range check: the chunk index is in range exactly when coord < count * edge
    assign lim_x = eff_count(cfg.chunks_x) * LIM_W'(CELLS_PER_CHUNK_EDGE);
    assign lim_y = eff_count(cfg.chunks_y) * LIM_W'(CELLS_PER_CHUNK_EDGE);
    assign lim_z = eff_count(cfg.chunks_z) * LIM_W'(CELLS_PER_CHUNK_EDGE);
    assign pos_x = x_reg[EDGE_W-1:0];
    assign pos_y = y_reg[EDGE_W-1:0];
    assign pos_z = z_reg[EDGE_W-1:0];

    always_comb
    begin
        in_range_next = (LIM_W'(x_reg) < lim_x) && (LIM_W'(y_reg) < lim_y)
                        && (LIM_W'(z_reg) < lim_z);
        if (in_range_next)
            addr_next = ADDR_W'(pos_z) * ADDR_W'(GRID_EDGE * GRID_EDGE)
                        + ADDR_W'(pos_y) * ADDR_W'(GRID_EDGE) + ADDR_W'(pos_x);
        else
            addr_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc_en)
        begin
            addr_reg     <= addr_next;
            in_range_reg <= in_range_next;
        end
    end

    // clearing pass counter
    assign clr_cnt_next = cmd.clear_en ? clr_cnt_reg + ADDR_W'(1) : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // modified cell value
    always_comb
    begin
        case (op_reg)
            cvcs_pkg::OP_SET: new_value = wv_reg;
            cvcs_pkg::OP_INC: new_value = rdata_reg + DATA_W'(1);
            cvcs_pkg::OP_DEC: new_value = rdata_reg - DATA_W'(1);
            default:          new_value = rdata_reg;
        endcase
    end

    // memory write port: clearing pass or execute
    always_comb
    begin
        if (cmd.clear_en)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = cmd.exec_en && in_range_reg && (op_reg != cvcs_pkg::OP_GET);
            mem_waddr = addr_reg;
            mem_wdata = new_value;
        end
    end

    // cell memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_en)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        if (cmd.exec_en)
        begin
            out_valid_next  = 1'b1;
            out_value_next  = (in_range_reg && op_reg == cvcs_pkg::OP_GET) ? rdata_reg : '0;
            out_status_next = in_range_reg ? cvcs_pkg::STATUS_DONE : cvcs_pkg::STATUS_RANGE;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.status     = out_status_reg;

endmodule

@@ rtl/cvcs_checker.sv @@
// port-level checks for the chunked voxel cell store, bound to the top level
module cvcs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [cvcs_pkg::DATA_W-1:0] rsp_read_value,
    input logic                        rsp_status
);

    // a held result word stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word dropped while stalled");

    // a held result word keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_read_value) && $stable(rsp_status))
        else $error("result payload changed while stalled");

    // an out-of-range result carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == cvcs_pkg::STATUS_RANGE |-> rsp_read_value == '0)
        else $error("out-of-range result with non-zero value");

    // one request in flight: no acceptance in the cycle after one
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in progress");

    // a result cannot appear the cycle after its request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("result appeared too early");

endmodule

bind chunked_voxel_cell_store cvcs_checker u_cvcs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_read_value (rsp.read_value),
    .rsp_status     (rsp.status)
);

@@ bench/tb.sv @@
// testbench for the chunked voxel cell store: directed edge cases, then random traffic checked against a local grid model
module tb;
    import cvcs_pkg::*;

    // grid geometry at the default parameters
    localparam int EDGE        = CELLS_PER_CHUNK_EDGE_DEF;
    localparam int MAX_SPAN    = MAX_CHUNKS_PER_AXIS_DEF;
    localparam int GRID_EDGE   = MAX_SPAN * EDGE;
    localparam int GRID_CELLS  = GRID_EDGE * GRID_EDGE * GRID_EDGE;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 800000;
    localparam int POOL_SIZE   = 8;

    // register byte addresses
    localparam logic [CFG_ADDR_W-1:0] ADDR_CHUNKS_X    = {REG_CHUNKS_X, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_CHUNKS_Y    = {REG_CHUNKS_Y, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_CHUNKS_Z    = {REG_CHUNKS_Z, 2'b00};
    // first address past the register list
    localparam logic [CFG_ADDR_W-1:0] ADDR_BEYOND_LIST = 4'd12;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     status;
    } cell_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    cvcs_req_if req_ch ();
    cvcs_rsp_if rsp_ch ();

    // model state: cell contents and chunk counts
    logic [DATA_W-1:0]  grid_cells [GRID_CELLS];
    logic [COUNT_W-1:0] span_x;
    logic [COUNT_W-1:0] span_y;
    logic [COUNT_W-1:0] span_z;

    cell_result_t result_queue [$];
    logic [COORD_W-1:0] hot_x [POOL_SIZE];
    logic [COORD_W-1:0] hot_y [POOL_SIZE];
    logic [COORD_W-1:0] hot_z [POOL_SIZE];

    bit idle_on;
    int hold_cnt;
    int cycle_count;
    int mismatch_count;
    int requests_sent;
    int results_seen;
    int outside_seen;
    int settings_used;

    chunked_voxel_cell_store dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still due",
                     cycle_count, result_queue.size());
            $display("** chunked_voxel_cell_store: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (mismatch_count < 40)
            $display("mismatch at cycle %0d: %s got %h expected %h",
                     cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // mostly short pauses, now and then a long one
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 92)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit axis_reachable(input logic [COORD_W-1:0] coord,
                                          input logic [COUNT_W-1:0] count);
        int eff;
        eff = (count > MAX_SPAN) ? MAX_SPAN : count;
        return (int'(coord) / EDGE) < eff;
    endfunction

    // grid model: applies one request and gives the word it should return
    function automatic cell_result_t predict_cell_op(input op_t op,
                                                     input logic [COORD_W-1:0] xc, yc, zc,
                                                     input logic [DATA_W-1:0] wv);
        cell_result_t res;
        int cell_idx;
        res.read_value = '0;
        res.status     = STATUS_DONE;
        if (!axis_reachable(xc, span_x) || !axis_reachable(yc, span_y) ||
            !axis_reachable(zc, span_z))
        begin
            res.status = STATUS_RANGE;
            return res;
        end
        // cell placement is fixed, independent of the chunk counts
        cell_idx = (int'(zc) * GRID_EDGE + int'(yc)) * GRID_EDGE + int'(xc);
        case (op)
            OP_GET: res.read_value = grid_cells[cell_idx];
            OP_SET: grid_cells[cell_idx] = wv;
            OP_INC: grid_cells[cell_idx] = grid_cells[cell_idx] + 1'b1;
            OP_DEC: grid_cells[cell_idx] = grid_cells[cell_idx] - 1'b1;
            default: ;
        endcase
        return res;
    endfunction

    // result word checker
    always @(posedge clk)
    begin
        cell_result_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            results_seen++;
            if (rsp_ch.status === STATUS_RANGE)
                outside_seen++;
            if (result_queue.size() == 0)
                report_mismatch("word with none due", rsp_ch.read_value, '0);
            else
            begin
                want = result_queue.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", DATA_W'(rsp_ch.status), DATA_W'(want.status));
                if (rsp_ch.read_value !== want.read_value)
                    report_mismatch("read_value", rsp_ch.read_value, want.read_value);
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (hold_cnt != 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_cnt <= pick_pause() - 1;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // send one request word, predicting its result once it is taken
    task automatic issue_request(input op_t op, input logic [COORD_W-1:0] xc, yc, zc,
                                 input logic [DATA_W-1:0] wv);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_pause() : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.x_coord     <= xc;
        req_ch.y_coord     <= yc;
        req_ch.z_coord     <= zc;
        req_ch.write_value <= wv;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        result_queue.push_back(predict_cell_op(op, xc, yc, zc, wv));
        requests_sent++;
    endtask

    // stop sending, let every due word arrive, then let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (result_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [COUNT_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= CFG_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        case (addr)
            ADDR_CHUNKS_X: span_x = value;
            ADDR_CHUNKS_Y: span_y = value;
            ADDR_CHUNKS_Z: span_z = value;
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [COUNT_W-1:0] want);
        logic [CFG_DATA_W-1:0] data;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (data !== CFG_DATA_W'(want))
            report_mismatch("register readback", data, CFG_DATA_W'(want));
    endtask

    // new chunk counts, written and read back while the block is idle
    task automatic set_counts(input logic [COUNT_W-1:0] cx, cy, cz);
        wait_idle();
        write_register(ADDR_CHUNKS_X, cx);
        write_register(ADDR_CHUNKS_Y, cy);
        write_register(ADDR_CHUNKS_Z, cz);
        check_register(ADDR_CHUNKS_X, cx);
        check_register(ADDR_CHUNKS_Y, cy);
        check_register(ADDR_CHUNKS_Z, cz);
        settings_used++;
    endtask

    function automatic logic [COORD_W-1:0] in_range_coord(input logic [COUNT_W-1:0] count);
        int eff;
        eff = (count > MAX_SPAN) ? MAX_SPAN : count;
        if (eff == 0)
            return COORD_W'($urandom_range(0, 255));
        return COORD_W'($urandom_range(0, eff * EDGE - 1));
    endfunction

    // last reachable or first unreachable coordinate on an axis
    function automatic logic [COORD_W-1:0] boundary_coord(input logic [COUNT_W-1:0] count);
        int eff;
        eff = (count > MAX_SPAN) ? MAX_SPAN : count;
        if (eff == 0)
            return COORD_W'($urandom_range(0, 255));
        return COORD_W'(eff * EDGE - int'($urandom_range(0, 1)));
    endfunction

    function automatic logic [DATA_W-1:0] pick_write_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // field extremes, every operation and wrap in both directions at the full grid
    task automatic test_edge_values();
        issue_request(OP_GET, 8'd0,   8'd0,   8'd0,   32'h1234_5678);
        issue_request(OP_SET, 8'd0,   8'd0,   8'd0,   32'h7FFF_FFFF);
        issue_request(OP_INC, 8'd0,   8'd0,   8'd0,   32'hFFFF_FFFF);
        issue_request(OP_GET, 8'd0,   8'd0,   8'd0,   32'h0);
        issue_request(OP_SET, 8'd31,  8'd31,  8'd31,  32'h8000_0000);
        issue_request(OP_DEC, 8'd31,  8'd31,  8'd31,  32'h0);
        issue_request(OP_GET, 8'd31,  8'd31,  8'd31,  32'h0);
        issue_request(OP_INC, 8'd255, 8'd0,   8'd0,   32'h0);
        issue_request(OP_SET, 8'd0,   8'd255, 8'd0,   32'hFFFF_FFFF);
        issue_request(OP_DEC, 8'd0,   8'd0,   8'd255, 32'h0);
        issue_request(OP_GET, 8'd32,  8'd31,  8'd31,  32'h0);
        issue_request(OP_SET, 8'd7,   8'd8,   8'd9,   32'hFFFF_FFFF);
        issue_request(OP_INC, 8'd7,   8'd8,   8'd9,   32'h0);
        issue_request(OP_GET, 8'd7,   8'd8,   8'd9,   32'h0);
    endtask

    // zero and oversized counts, small counts, ignored address, cells kept over rewrites
    task automatic test_count_limits();
        set_counts(3'd0, 3'd4, 3'd4);
        issue_request(OP_GET, 8'd0,  8'd0,  8'd0,  32'h0);
        issue_request(OP_SET, 8'd0,  8'd5,  8'd5,  32'h5555_AAAA);
        set_counts(3'd7, 3'd6, 3'd5);
        issue_request(OP_GET, 8'd31, 8'd31, 8'd31, 32'h0);
        issue_request(OP_GET, 8'd31, 8'd32, 8'd0,  32'h0);
        set_counts(3'd1, 3'd2, 3'd3);
        issue_request(OP_GET, 8'd7,  8'd15, 8'd23, 32'h0);
        issue_request(OP_GET, 8'd8,  8'd0,  8'd0,  32'h0);
        issue_request(OP_GET, 8'd0,  8'd16, 8'd0,  32'h0);
        issue_request(OP_GET, 8'd0,  8'd0,  8'd24, 32'h0);
        wait_idle();
        write_register(ADDR_BEYOND_LIST, 3'd4);
        check_register(ADDR_CHUNKS_X, span_x);
        issue_request(OP_INC, 8'd8,  8'd0,  8'd0,  32'h0);
        set_counts(3'd4, 3'd4, 3'd4);
        issue_request(OP_GET, 8'd0,  8'd0,  8'd0,  32'h0);
    endtask

    // one random phase at fixed chunk counts
    task automatic run_phase(input logic [COUNT_W-1:0] cx, cy, cz, input bit with_idle,
                             input int count);
        int r;
        int sel;
        int axis;
        logic [COORD_W-1:0] xc, yc, zc;
        set_counts(cx, cy, cz);
        idle_on = with_idle;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            hot_x[i] = in_range_coord(span_x);
            hot_y[i] = in_range_coord(span_y);
            hot_z[i] = in_range_coord(span_z);
        end
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                // a few cells hit again and again, so updates pile up back to back
                sel = $urandom_range(0, POOL_SIZE - 1);
                xc = hot_x[sel];
                yc = hot_y[sel];
                zc = hot_z[sel];
            end
            else if (r < 85)
            begin
                xc = in_range_coord(span_x);
                yc = in_range_coord(span_y);
                zc = in_range_coord(span_z);
            end
            else if (r < 92)
            begin
                axis = $urandom_range(0, 2);
                xc = (axis == 0) ? boundary_coord(span_x) : in_range_coord(span_x);
                yc = (axis == 1) ? boundary_coord(span_y) : in_range_coord(span_y);
                zc = (axis == 2) ? boundary_coord(span_z) : in_range_coord(span_z);
            end
            else
            begin
                xc = COORD_W'($urandom_range(0, 255));
                yc = COORD_W'($urandom_range(0, 255));
                zc = COORD_W'($urandom_range(0, 255));
            end
            issue_request(op_t'($urandom_range(0, 3)), xc, yc, zc, pick_write_value());
        end
    endtask

    task automatic test_random_traffic();
        run_phase(3'd4, 3'd4, 3'd4, 1'b1, 400);
        run_phase(3'd1, 3'd1, 3'd1, 1'b1, 250);
        run_phase(3'd7, 3'd2, 3'd3, 1'b0, 250);
        run_phase(3'd3, 3'd5, 3'd1, 1'b1, 250);
        run_phase(3'd0, 3'd4, 3'd2, 1'b1, 100);
        run_phase(3'd2, 3'd4, 3'd6, 1'b1, 200);
        run_phase(COUNT_W'($urandom_range(0, 7)), COUNT_W'($urandom_range(0, 7)),
                  COUNT_W'($urandom_range(0, 7)), 1'b1, 150);
        run_phase(3'd4, 3'd4, 3'd4, 1'b0, 250);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.op          = OP_GET;
        req_ch.x_coord     = '0;
        req_ch.y_coord     = '0;
        req_ch.z_coord     = '0;
        req_ch.write_value = '0;
        rsp_ch.ready       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        idle_on            = 1'b1;
        hold_cnt           = 0;
        span_x             = CHUNKS_RESET;
        span_y             = CHUNKS_RESET;
        span_z             = CHUNKS_RESET;
        foreach (grid_cells[i])
            grid_cells[i] = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // the clearing pass holds requests off until it is done
        do @(posedge clk); while (req_ch.ready !== 1'b1);

        test_edge_values();
        test_count_limits();
        test_random_traffic();
        wait_idle();

        $display("run covered %0d requests and %0d result words, %0d outside the grid",
                 requests_sent, results_seen, outside_seen);
        $display("over %0d chunk-count settings, with and without idle gaps on both sides",
                 settings_used);
        if (mismatch_count == 0)
            $display("** chunked_voxel_cell_store: PASSED **");
        else
            $display("** chunked_voxel_cell_store: FAILED **");
        $finish;
    end

endmodule
